### rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer package
// Shared types, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned IntervalW = 10;
  localparam int unsigned CountW    = 8;
  localparam int unsigned MsW       = 16;
  localparam int unsigned HalfW     = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 8;

  localparam logic [IntervalW-1:0] SlowIntervalRst = IntervalW'(500);
  localparam logic [IntervalW-1:0] FastIntervalRst = IntervalW'(250);
  localparam logic [CountW-1:0]    SlowTotalRst    = CountW'(105);
  localparam logic [CountW-1:0]    FastTotalRst    = CountW'(30);
  localparam logic [MsW-1:0]       SeqBeepMsRst    = MsW'(100);

  localparam logic [HalfW-1:0] HalfHigh = HalfW'(1);
  localparam logic [HalfW-1:0] HalfLow  = HalfW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOW_INTERVAL = 3'd0,
    CFG_FAST_INTERVAL = 3'd1,
    CFG_SLOW_TOTAL    = 3'd2,
    CFG_FAST_TOTAL    = 3'd3,
    CFG_SEQ_BEEP_MS   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_SLOW = 2'd1,
    PHASE_FAST = 2'd2
  } phase_e;

  // Control from the top level into the tone generator for one tick.
  typedef struct packed {
    logic           step;
    logic           direct_req;
    logic           direct_low_pitch;
    logic [MsW-1:0] direct_ms;
    logic           seq_beep;
    logic [MsW-1:0] seq_ms;
  } tone_ctrl_t;

  // Tone state after the tick being processed.
  typedef struct packed {
    logic busy;
    logic speaker;
  } tone_stat_t;

  // Ticks a tone lasts: (ms + 1) / 2.
  function automatic logic [MsW-1:0] ms_to_ticks(input logic [MsW-1:0] ms);
    logic [MsW:0] sum;
    sum = {1'b0, ms} + (MsW+1)'(1);
    return sum[MsW:1];
  endfunction

endpackage

### rtl/bps_tone.sv
// ----------------------------------------------------------------------------
// Beep pattern tone generator
// Holds the tone timer and toggles the speaker at the selected half period.
// ----------------------------------------------------------------------------
module bps_tone (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bps_pkg::tone_ctrl_t ctrl_i,
  output bps_pkg::tone_stat_t stat_o
);

  logic                          on_q, on_d;
  logic                          spk_q, spk_d;
  logic [bps_pkg::MsW-1:0]       elapsed_q, elapsed_d;
  logic [bps_pkg::MsW-1:0]       last_q, last_d;
  logic [bps_pkg::HalfW-1:0]     half_q, half_d;
  logic [bps_pkg::MsW-1:0]       len_q, len_d;

  always_comb begin
    logic [bps_pkg::MsW-1:0] since;
    on_d      = on_q;
    spk_d     = spk_q;
    elapsed_d = elapsed_q;
    last_d    = last_q;
    half_d    = half_q;
    len_d     = len_q;

    // A direct request starts a tone only when none is sounding.
    if (ctrl_i.direct_req && !on_d) begin
      on_d      = 1'b1;
      spk_d     = 1'b0;
      len_d     = bps_pkg::ms_to_ticks(ctrl_i.direct_ms);
      half_d    = ctrl_i.direct_low_pitch ? bps_pkg::HalfLow : bps_pkg::HalfHigh;
      elapsed_d = '0;
    end

    if (elapsed_d != '1) begin
      elapsed_d = elapsed_d + bps_pkg::MsW'(1);
    end

    since = elapsed_d - last_d;
    if (!on_d) begin
      spk_d = 1'b0;
    end else begin
      if (since >= {{(bps_pkg::MsW-bps_pkg::HalfW){1'b0}}, half_d}) begin
        spk_d  = ~spk_d;
        last_d = elapsed_d;
      end
      if (elapsed_d >= len_d) begin
        on_d   = 1'b0;
        spk_d  = 1'b0;
        last_d = '0;
      end
    end

    // Sequencer beeps are low pitch and are dropped while a tone sounds.
    if (ctrl_i.seq_beep && !on_d) begin
      on_d      = 1'b1;
      spk_d     = 1'b0;
      len_d     = bps_pkg::ms_to_ticks(ctrl_i.seq_ms);
      half_d    = bps_pkg::HalfLow;
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q      <= 1'b0;
      spk_q     <= 1'b0;
      elapsed_q <= '0;
      last_q    <= '0;
      half_q    <= '0;
      len_q     <= '0;
    end else if (ctrl_i.step) begin
      on_q      <= on_d;
      spk_q     <= spk_d;
      elapsed_q <= elapsed_d;
      last_q    <= last_d;
      half_q    <= half_d;
      len_q     <= len_d;
    end
  end

  assign stat_o.busy    = on_d;
  assign stat_o.speaker = spk_d;

endmodule

### rtl/beep_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer core
// Speaker driver with direct beeps and a slow/fast beep pattern sequencer.
// ----------------------------------------------------------------------------
// Path: a tick transaction is captured in the input register, and its result is
// registered in the result register before it leaves on the output stream.
// Throughput: one tick per cycle unless the output stalls; the whole tick update
// fits between the input and result registers; pattern state updates each tick.
// Reset: rst_ni clears all control state and loads the default register values.
module beep_pattern_sequencer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bps_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0]     cfg_data_i,
  // Tick input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: [0] start_pulse, [1] stop_pulse, [2] beep_request,
  //        [3] beep_low_pitch, [19:4] beep_length_ms, [23:20] zero
  input  logic [bps_pkg::InDataW-1:0]      s_axis_tdata_i,
  // Result output stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: [0] speaker_level, [2:1] sequence_phase, [3] tone_busy, [7:4] zero
  output logic [bps_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are taken in every cycle; the user writes
  // them only while no tick is in flight.
  // --------------------------------------------------------------------------
  logic [bps_pkg::IntervalW-1:0] slow_interval_q, fast_interval_q;
  logic [bps_pkg::CountW-1:0]    slow_total_q, fast_total_q;
  logic [bps_pkg::MsW-1:0]       seq_ms_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_interval_q <= bps_pkg::SlowIntervalRst;
      fast_interval_q <= bps_pkg::FastIntervalRst;
      slow_total_q    <= bps_pkg::SlowTotalRst;
      fast_total_q    <= bps_pkg::FastTotalRst;
      seq_ms_q        <= bps_pkg::SeqBeepMsRst;
    end else if (cfg_valid_i) begin
      case (bps_pkg::cfg_idx_e'(cfg_index_i))
        bps_pkg::CFG_SLOW_INTERVAL: slow_interval_q <= cfg_data_i[bps_pkg::IntervalW-1:0];
        bps_pkg::CFG_FAST_INTERVAL: fast_interval_q <= cfg_data_i[bps_pkg::IntervalW-1:0];
        bps_pkg::CFG_SLOW_TOTAL:    slow_total_q    <= cfg_data_i[bps_pkg::CountW-1:0];
        bps_pkg::CFG_FAST_TOTAL:    fast_total_q    <= cfg_data_i[bps_pkg::CountW-1:0];
        bps_pkg::CFG_SEQ_BEEP_MS:   seq_ms_q        <= cfg_data_i[bps_pkg::MsW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Two-register pipeline. The input register takes a new transaction
  // whenever it is empty or drains in the same cycle. A waiting result holds
  // the tick behind it in the input register, and the input stalls only once
  // both registers are full.
  // --------------------------------------------------------------------------
  logic                          in_valid_q;
  logic [bps_pkg::InDataW-1:0]   in_data_q;
  logic                          out_valid_q;
  logic [bps_pkg::OutDataW-1:0]  out_data_q, out_data_d;
  logic                          advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Unpack the captured tick.
  logic                    tick_start, tick_stop, tick_req, tick_low;
  logic [bps_pkg::MsW-1:0] tick_ms;

  assign tick_start = in_data_q[0];
  assign tick_stop  = in_data_q[1];
  assign tick_req   = in_data_q[2];
  assign tick_low   = in_data_q[3];
  assign tick_ms    = in_data_q[19:4];

  // --------------------------------------------------------------------------
  // Pattern sequencer. The start and stop pulses are sticky: a stop seen while
  // idle waits and ends the next run on its first tick. A phase ends after
  // its beep total; a total of zero ends it after the first beep.
  // --------------------------------------------------------------------------
  logic                          start_q, start_d;
  logic                          stop_q, stop_d;
  bps_pkg::phase_e               phase_q, phase_d;
  logic [bps_pkg::IntervalW-1:0] interval_q, interval_d;
  logic [bps_pkg::CountW-1:0]    count_q, count_d;
  logic                          seq_beep;

  always_comb begin
    logic [bps_pkg::IntervalW-1:0] limit;
    logic [bps_pkg::CountW-1:0]    total;
    start_d    = start_q | tick_start;
    stop_d     = stop_q | tick_stop;
    phase_d    = phase_q;
    count_d    = count_q;
    seq_beep   = 1'b0;
    interval_d = (interval_q != '1) ? interval_q + bps_pkg::IntervalW'(1) : interval_q;
    limit      = (phase_q == bps_pkg::PHASE_FAST) ? fast_interval_q : slow_interval_q;
    total      = (phase_q == bps_pkg::PHASE_FAST) ? fast_total_q : slow_total_q;

    case (phase_q)
      bps_pkg::PHASE_IDLE: begin
        if (start_d) begin
          phase_d    = bps_pkg::PHASE_SLOW;
          interval_d = '0;
          count_d    = '0;
        end
      end
      bps_pkg::PHASE_SLOW, bps_pkg::PHASE_FAST: begin
        if (stop_d) begin
          phase_d = bps_pkg::PHASE_IDLE;
          start_d = 1'b0;
          stop_d  = 1'b0;
          count_d = '0;
        end else if (interval_d >= limit) begin
          seq_beep   = 1'b1;
          interval_d = '0;
          count_d    = count_q + bps_pkg::CountW'(1);
          if (count_d >= total) begin
            count_d = '0;
            if (phase_q == bps_pkg::PHASE_FAST) begin
              // Only the start latch is cleared at the natural end.
              phase_d = bps_pkg::PHASE_IDLE;
              start_d = 1'b0;
            end else begin
              phase_d = bps_pkg::PHASE_FAST;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= 1'b0;
      stop_q     <= 1'b0;
      phase_q    <= bps_pkg::PHASE_IDLE;
      interval_q <= '0;
      count_q    <= '0;
    end else if (advance) begin
      start_q    <= start_d;
      stop_q     <= stop_d;
      phase_q    <= phase_d;
      interval_q <= interval_d;
      count_q    <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Tone generator. It sees the direct request first and the sequencer beep
  // last, after its own timer has run for this tick.
  // --------------------------------------------------------------------------
  bps_pkg::tone_ctrl_t tone_ctrl;
  bps_pkg::tone_stat_t tone_stat;

  assign tone_ctrl.step             = advance;
  assign tone_ctrl.direct_req       = tick_req;
  assign tone_ctrl.direct_low_pitch = tick_low;
  assign tone_ctrl.direct_ms        = tick_ms;
  assign tone_ctrl.seq_beep         = seq_beep;
  assign tone_ctrl.seq_ms           = seq_ms_q;

  bps_tone u_tone (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tone_ctrl),
    .stat_o (tone_stat)
  );

  assign out_data_d = {4'b0000, tone_stat.busy, phase_d, tone_stat.speaker};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A silent tone generator never drives the speaker high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[3]) |-> !m_axis_tdata_o[0])
    else $error("speaker high while no tone is busy");

  // Every return to idle clears the start latch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != bps_pkg::PHASE_IDLE) ##1 (phase_q == bps_pkg::PHASE_IDLE) |-> !start_q)
    else $error("start latch left set after a run ended");

  // A new run begins with a cleared interval timer and beep count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(phase_q) == bps_pkg::PHASE_IDLE && phase_q == bps_pkg::PHASE_SLOW)
      |-> (interval_q == '0 && count_q == '0))
    else $error("run started with stale timer or count");

endmodule
